// ===== design/olid_pkg.sv =====
// Shared types and codes for the ordered list engine.
package olid_pkg;

  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 8;
  localparam int POSITION_W = 8;
  localparam int COUNT_W    = 9;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int SCAN_STRIDE = 8;
  localparam int SCAN_SEL_W  = 3;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd3;

  // What a cell loads into its entry this cycle.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LEFT  = 2'd1,
    CELL_RIGHT = 2'd2,
    CELL_LOAD  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     hit_load;
    logic     hit_shift;
    logic     in_range;
  } cell_ctl_t;

endpackage

// ===== design/olid_if.sv =====
// Request and response channel interfaces of the ordered list engine.
interface olid_req_if;
  logic                                valid;
  logic                                ready;
  logic [olid_pkg::MODE_W-1:0]         mode;
  logic [olid_pkg::INDEX_W-1:0]        index;
  logic signed [olid_pkg::VALUE_W-1:0] value;

  modport source(output valid, mode, index, value, input ready);
  modport sink(input valid, mode, index, value, output ready);
endinterface

interface olid_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [olid_pkg::STATUS_W-1:0]    status;
  logic [olid_pkg::POSITION_W-1:0]  position;
  logic [olid_pkg::COUNT_W-1:0]     count;

  modport source(output valid, status, position, count, input ready);
  modport sink(input valid, status, position, count, output ready);
endinterface

// ===== design/olid_cell.sv =====
// One list cell: holds one entry and one match bit of the scan line.
module olid_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  olid_pkg::cell_ctl_t                 ctl,
  input  logic signed [olid_pkg::VALUE_W-1:0] value,
  input  logic signed [olid_pkg::VALUE_W-1:0] left,
  input  logic signed [olid_pkg::VALUE_W-1:0] right,
  input  logic                                hit_up,
  output logic signed [olid_pkg::VALUE_W-1:0] entry,
  output logic                                hit
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      olid_pkg::CELL_LEFT:  entry <= left;
      olid_pkg::CELL_RIGHT: entry <= right;
      olid_pkg::CELL_LOAD:  entry <= value;
      default:              entry <= entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.hit_load) begin
      hit <= ctl.in_range && (entry == value);
    end else if (ctl.hit_shift) begin
      hit <= hit_up;
    end
  end

endmodule

// ===== design/ordered_list_insert_delete_find.sv =====
// Ordered list engine: a row of CAPACITY cells, one entry each, kept in positions
// 0 .. count-1. A request is taken only while the engine is idle. Append, insert and
// delete are carried out in the execute state, in which the cells from the target
// position upward shift or load in parallel, with the response registered at the end
// of it; the engine then returns to idle for the next request. Find compares all cells
// at once, then scans the match bits eight positions a cycle from position 0,
// stopping at the first match or at the end of the list, where the response is
// registered and the engine returns to idle. A response that cannot be delivered
// waits in the output register. If that register is still occupied when a result is
// ready, the engine holds the result and takes no request until the register frees.
module ordered_list_insert_delete_find #(
  parameter int CAPACITY = 256
) (
  input logic        clk,
  input logic        rst,
  olid_req_if.sink   req,
  olid_rsp_if.source rsp
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SW  = $clog2(CAPACITY + olid_pkg::SCAN_STRIDE + 1);
  localparam int PW  = (SW > olid_pkg::COUNT_W) ? SW : olid_pkg::COUNT_W;
  localparam int NWIN = (CAPACITY < olid_pkg::SCAN_STRIDE) ? CAPACITY : olid_pkg::SCAN_STRIDE;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [olid_pkg::MODE_W-1:0]         op_mode;
  logic [olid_pkg::INDEX_W-1:0]        op_index;
  logic signed [olid_pkg::VALUE_W-1:0] op_value;
  logic [CW-1:0]                       count, count_next;
  logic [PW-1:0]                       base;

  logic                                rsp_valid;
  logic [olid_pkg::STATUS_W-1:0]       rsp_status, pend_status;
  logic [olid_pkg::POSITION_W-1:0]     rsp_position, pend_position;
  logic [olid_pkg::COUNT_W-1:0]        rsp_count;

  logic signed [olid_pkg::VALUE_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]                 hits;
  olid_pkg::cell_ctl_t                 cell_ctl [CAPACITY];

  logic [PW-1:0] cnt_x, idx_x;
  logic          full, in_idx, exec, do_append, do_insert, do_delete, do_find;
  logic          req_take, out_free;
  logic [olid_pkg::SCAN_STRIDE-1:0] window;
  logic [olid_pkg::SCAN_SEL_W-1:0]  sel;
  logic          win_any, scan_end, scan_done, scan_shift;
  logic          res_ready;
  logic [olid_pkg::STATUS_W-1:0]   res_status;
  logic [olid_pkg::POSITION_W-1:0] res_position;
  logic [PW-1:0]                   exec_pos, scan_pos;

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  assign cnt_x  = PW'(count);
  assign idx_x  = PW'(op_index);
  assign full   = (cnt_x == PW'(CAPACITY));
  assign in_idx = (idx_x < cnt_x);

  assign exec      = (state == ST_EXEC);
  assign do_append = exec && (op_mode == olid_pkg::MODE_APPEND) && !full;
  assign do_insert = exec && (op_mode == olid_pkg::MODE_INSERT) && !full && in_idx;
  assign do_delete = exec && (op_mode == olid_pkg::MODE_DELETE) && in_idx;
  assign do_find   = exec && (op_mode == olid_pkg::MODE_FIND);

  // Cell row
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    localparam logic [PW-1:0] POS = PW'(gi);
    logic signed [olid_pkg::VALUE_W-1:0] left_n, right_n;
    logic                                up_n;

    if (gi == 0) begin : g_first
      assign left_n = entry[gi];
    end else begin : g_mid_l
      assign left_n = entry[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign right_n = entry[gi];
    end else begin : g_mid_r
      assign right_n = entry[gi+1];
    end

    if (gi + olid_pkg::SCAN_STRIDE < CAPACITY) begin : g_up
      assign up_n = hits[gi + olid_pkg::SCAN_STRIDE];
    end else begin : g_up_end
      assign up_n = 1'b0;
    end

    assign cell_ctl[gi].op =
      ((do_append && POS == cnt_x) || (do_insert && POS == idx_x)) ? olid_pkg::CELL_LOAD :
      (do_insert && POS > idx_x)  ? olid_pkg::CELL_LEFT  :
      (do_delete && POS >= idx_x) ? olid_pkg::CELL_RIGHT :
                                    olid_pkg::CELL_HOLD;
    assign cell_ctl[gi].hit_load  = do_find;
    assign cell_ctl[gi].hit_shift = scan_shift;
    assign cell_ctl[gi].in_range  = (POS < cnt_x);

    olid_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (cell_ctl[gi]),
      .value  (op_value),
      .left   (left_n),
      .right  (right_n),
      .hit_up (up_n),
      .entry  (entry[gi]),
      .hit    (hits[gi])
    );
  end

  // Scan window: the lowest eight match bits of the row
  for (genvar gw = 0; gw < olid_pkg::SCAN_STRIDE; gw++) begin : g_win
    if (gw < NWIN) begin : g_bit
      assign window[gw] = hits[gw];
    end else begin : g_pad
      assign window[gw] = 1'b0;
    end
  end

  always_comb begin
    sel = '0;
    for (int k = olid_pkg::SCAN_STRIDE - 1; k >= 0; k--) begin
      if (window[k]) sel = olid_pkg::SCAN_SEL_W'(k);
    end
  end

  assign win_any    = |window;
  assign scan_end   = ((base + PW'(olid_pkg::SCAN_STRIDE)) >= cnt_x);
  assign scan_done  = (state == ST_SCAN) && (win_any || scan_end);
  assign scan_shift = (state == ST_SCAN) && !win_any && !scan_end;
  assign scan_pos   = base + PW'(sel);

  // Result of the current operation
  always_comb begin
    count_next = count;
    exec_pos   = '0;
    res_status = olid_pkg::STATUS_OK;
    res_ready  = 1'b0;
    if (exec) begin
      case (op_mode)
        olid_pkg::MODE_APPEND: begin
          res_ready = 1'b1;
          if (full) begin
            res_status = olid_pkg::STATUS_FULL;
          end else begin
            exec_pos   = cnt_x;
            count_next = count + CW'(1);
          end
        end
        olid_pkg::MODE_INSERT: begin
          res_ready = 1'b1;
          if (full) begin
            res_status = olid_pkg::STATUS_FULL;
          end else if (!in_idx) begin
            res_status = olid_pkg::STATUS_RANGE;
          end else begin
            exec_pos   = idx_x;
            count_next = count + CW'(1);
          end
        end
        olid_pkg::MODE_DELETE: begin
          res_ready = 1'b1;
          if (!in_idx) begin
            res_status = olid_pkg::STATUS_RANGE;
          end else begin
            exec_pos   = idx_x;
            count_next = count - CW'(1);
          end
        end
        default: begin
          res_ready = 1'b0;
        end
      endcase
      res_position = exec_pos[olid_pkg::POSITION_W-1:0];
    end else begin
      res_ready    = scan_done;
      res_status   = win_any ? olid_pkg::STATUS_OK : olid_pkg::STATUS_ABSENT;
      res_position = win_any ? scan_pos[olid_pkg::POSITION_W-1:0] : '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_take) state_next = ST_EXEC;
      ST_EXEC: begin
        if (op_mode == olid_pkg::MODE_FIND) state_next = ST_SCAN;
        else state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_SCAN: if (scan_done) state_next = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      op_mode  <= req.mode;
      op_index <= req.index;
      op_value <= req.value;
    end
    if (do_find) begin
      base <= '0;
    end else if (scan_shift) begin
      base <= base + PW'(olid_pkg::SCAN_STRIDE);
    end
    // keep the result while the output register is still occupied
    if (res_ready) begin
      pend_status   <= res_status;
      pend_position <= res_position;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready && out_free) begin
      rsp_valid <= 1'b1;
    end else if (state == ST_HOLD && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && out_free) begin
      rsp_status   <= res_status;
      rsp_position <= res_position;
      rsp_count    <= olid_pkg::COUNT_W'(PW'(count_next));
    end else if (state == ST_HOLD && out_free) begin
      rsp_status   <= pend_status;
      rsp_position <= pend_position;
      rsp_count    <= olid_pkg::COUNT_W'(cnt_x);
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.status   = rsp_status;
  assign rsp.position = rsp_position;
  assign rsp.count    = rsp_count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_x <= PW'(CAPACITY))
    else $error("entry count above capacity");

  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == ST_EXEC)
    else $error("accepted request not executed");

  a_scan_base: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> (base < cnt_x || cnt_x == '0))
    else $error("scan window past end of list");

  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_HOLD |-> rsp_valid)
    else $error("result held while output register empty");

endmodule

// ===== dv/tb_ordered_list_insert_delete_find.sv =====
// Testbench for the ordered list engine: directed table, fill to capacity, random walk.
module tb_ordered_list_insert_delete_find;

  localparam int LIST_CAPACITY = 256;
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic [olid_pkg::STATUS_W-1:0]   status;
    logic [olid_pkg::POSITION_W-1:0] position;
    logic [olid_pkg::COUNT_W-1:0]    count;
  } list_result_t;

  typedef struct packed {
    logic [olid_pkg::MODE_W-1:0]         op;
    logic [olid_pkg::INDEX_W-1:0]        idx;
    logic signed [olid_pkg::VALUE_W-1:0] val;
    logic                                typed;
    list_result_t                        res;
  } list_step_t;

  localparam logic signed [olid_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [olid_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [olid_pkg::VALUE_W-1:0] VAL_NEG = 32'shFFFF_FFFF;
  localparam logic signed [olid_pkg::VALUE_W-1:0] VAL_ALT = 32'sh5555_5555;
  localparam logic signed [olid_pkg::VALUE_W-1:0] VAL_OFF = 32'shAAAA_AAAA;

  localparam int DIRECTED_ROWS = 22;

  // Typed rows carry their own expectation; the rest are checked against the list predictor.
  list_step_t directed_steps [DIRECTED_ROWS] = '{
    '{olid_pkg::MODE_FIND,   8'd0,   32'sd0,  1'b1, '{olid_pkg::STATUS_ABSENT, 8'd0, 9'd0}},
    '{olid_pkg::MODE_DELETE, 8'd0,   32'sd0,  1'b1, '{olid_pkg::STATUS_RANGE,  8'd0, 9'd0}},
    '{olid_pkg::MODE_INSERT, 8'd0,   32'sd7,  1'b1, '{olid_pkg::STATUS_RANGE,  8'd0, 9'd0}},
    '{olid_pkg::MODE_APPEND, 8'd255, VAL_MIN, 1'b1, '{olid_pkg::STATUS_OK,     8'd0, 9'd1}},
    '{olid_pkg::MODE_APPEND, 8'd0,   VAL_MAX, 1'b1, '{olid_pkg::STATUS_OK,     8'd1, 9'd2}},
    '{olid_pkg::MODE_APPEND, 8'd0,   32'sd0,  1'b1, '{olid_pkg::STATUS_OK,     8'd2, 9'd3}},
    '{olid_pkg::MODE_APPEND, 8'd0,   VAL_NEG, 1'b1, '{olid_pkg::STATUS_OK,     8'd3, 9'd4}},
    '{olid_pkg::MODE_INSERT, 8'd0,   32'sd5,  1'b1, '{olid_pkg::STATUS_OK,     8'd0, 9'd5}},
    '{olid_pkg::MODE_INSERT, 8'd4,   VAL_ALT, 1'b1, '{olid_pkg::STATUS_OK,     8'd4, 9'd6}},
    '{olid_pkg::MODE_INSERT, 8'd255, VAL_OFF, 1'b1, '{olid_pkg::STATUS_RANGE,  8'd0, 9'd6}},
    '{olid_pkg::MODE_INSERT, 8'd6,   32'sd1,  1'b1, '{olid_pkg::STATUS_RANGE,  8'd0, 9'd6}},
    '{olid_pkg::MODE_FIND,   8'd0,   VAL_MAX, 1'b0, '{olid_pkg::STATUS_OK,     8'd0, 9'd0}},
    '{olid_pkg::MODE_FIND,   8'd0,   VAL_NEG, 1'b0, '{olid_pkg::STATUS_OK,     8'd0, 9'd0}},
    '{olid_pkg::MODE_FIND,   8'd255, VAL_OFF, 1'b1, '{olid_pkg::STATUS_ABSENT, 8'd0, 9'd6}},
    '{olid_pkg::MODE_DELETE, 8'd6,   32'sd0,  1'b1, '{olid_pkg::STATUS_RANGE,  8'd0, 9'd6}},
    '{olid_pkg::MODE_DELETE, 8'd255, 32'sd0,  1'b1, '{olid_pkg::STATUS_RANGE,  8'd0, 9'd6}},
    '{olid_pkg::MODE_DELETE, 8'd5,   32'sd0,  1'b0, '{olid_pkg::STATUS_OK,     8'd0, 9'd0}},
    '{olid_pkg::MODE_DELETE, 8'd0,   32'sd0,  1'b0, '{olid_pkg::STATUS_OK,     8'd0, 9'd0}},
    '{olid_pkg::MODE_APPEND, 8'd0,   32'sd0,  1'b0, '{olid_pkg::STATUS_OK,     8'd0, 9'd0}},
    '{olid_pkg::MODE_FIND,   8'd0,   32'sd0,  1'b0, '{olid_pkg::STATUS_OK,     8'd0, 9'd0}},
    '{olid_pkg::MODE_FIND,   8'd0,   VAL_MIN, 1'b0, '{olid_pkg::STATUS_OK,     8'd0, 9'd0}},
    '{olid_pkg::MODE_DELETE, 8'd0,   32'sd0,  1'b0, '{olid_pkg::STATUS_OK,     8'd0, 9'd0}}
  };

  logic clk;
  logic rst;

  olid_req_if req_ch ();
  olid_rsp_if rsp_ch ();

  ordered_list_insert_delete_find #(
    .CAPACITY(LIST_CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Predicted list contents and length
  logic signed [olid_pkg::VALUE_W-1:0] list_mem [LIST_CAPACITY];
  int                                  list_len;
  list_result_t                        pending_results [$];

  int errors;
  int requests_sent;
  int results_seen;
  int status_seen [4];
  int cycle_count;
  int src_idle_pct;
  int rcv_idle_pct;
  int hold_left;
  bit long_hold_done;
  bit growing;
  int turn_mark;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("tb_ordered_list_insert_delete_find failed");
      $finish;
    end
  end

  function automatic list_result_t predict_list_op(
    logic [olid_pkg::MODE_W-1:0] op,
    logic [olid_pkg::INDEX_W-1:0] idx,
    logic signed [olid_pkg::VALUE_W-1:0] val);
    list_result_t r;
    int           i;
    r.status   = olid_pkg::STATUS_OK;
    r.position = '0;
    case (op)
      olid_pkg::MODE_APPEND: begin
        if (list_len >= LIST_CAPACITY) begin
          r.status = olid_pkg::STATUS_FULL;
        end else begin
          list_mem[list_len] = val;
          r.position = list_len[olid_pkg::POSITION_W-1:0];
          list_len++;
        end
      end
      olid_pkg::MODE_INSERT: begin
        if (list_len >= LIST_CAPACITY) begin
          r.status = olid_pkg::STATUS_FULL;
        end else if (int'(idx) >= list_len) begin
          r.status = olid_pkg::STATUS_RANGE;
        end else begin
          for (i = list_len; i > int'(idx); i--) list_mem[i] = list_mem[i-1];
          list_mem[idx] = val;
          list_len++;
          r.position = idx;
        end
      end
      olid_pkg::MODE_DELETE: begin
        if (int'(idx) >= list_len) begin
          r.status = olid_pkg::STATUS_RANGE;
        end else begin
          for (i = int'(idx); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          r.position = idx;
        end
      end
      default: begin
        r.status = olid_pkg::STATUS_ABSENT;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            r.status   = olid_pkg::STATUS_OK;
            r.position = i[olid_pkg::POSITION_W-1:0];
            break;
          end
        end
      end
    endcase
    r.count = list_len[olid_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Random value: full range, a narrow band that breeds duplicates, or an extreme
  function automatic logic signed [olid_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $signed($urandom);
    if (r < 80) return $signed($urandom_range(0, 15)) - 8;
    case ($urandom_range(0, 3))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return 32'sd0;
      default: return VAL_NEG;
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(logic [olid_pkg::MODE_W-1:0] op,
                              logic [olid_pkg::INDEX_W-1:0] idx,
                              logic signed [olid_pkg::VALUE_W-1:0] val, logic typed,
                              list_result_t typed_res);
    list_result_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= op;
    req_ch.index <= idx;
    req_ch.value <= val;
    do @(posedge clk); while (!req_ch.ready);
    r = predict_list_op(op, idx, val);
    pending_results.push_back(typed ? typed_res : r);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic random_requests(int n);
    logic [olid_pkg::MODE_W-1:0]         op;
    logic [olid_pkg::INDEX_W-1:0]        idx;
    logic signed [olid_pkg::VALUE_W-1:0] val;
    int                                  r;
    repeat (n) begin
      // Sweep the length up to a random mark and back down towards empty
      if (growing && list_len >= turn_mark) begin
        growing   = 1'b0;
        turn_mark = $urandom_range(0, 6);
      end else if (!growing && list_len <= turn_mark) begin
        growing   = 1'b1;
        turn_mark = ($urandom_range(0, 3) == 0) ? LIST_CAPACITY : $urandom_range(8, 64);
      end
      r = $urandom_range(0, 99);
      if (growing)
        op = (r < 35) ? olid_pkg::MODE_APPEND :
             (r < 65) ? olid_pkg::MODE_INSERT :
             (r < 80) ? olid_pkg::MODE_DELETE : olid_pkg::MODE_FIND;
      else
        op = (r < 5)  ? olid_pkg::MODE_APPEND :
             (r < 10) ? olid_pkg::MODE_INSERT :
             (r < 80) ? olid_pkg::MODE_DELETE : olid_pkg::MODE_FIND;
      r = $urandom_range(0, 99);
      if (list_len > 0 && r < 85) idx = olid_pkg::INDEX_W'($urandom_range(0, list_len - 1));
      else if (r < 93) idx = list_len[olid_pkg::INDEX_W-1:0];
      else idx = olid_pkg::INDEX_W'($urandom_range(0, 255));
      if (op == olid_pkg::MODE_FIND && list_len > 0 && $urandom_range(0, 99) < 70)
        val = list_mem[$urandom_range(0, list_len - 1)];
      else
        val = pick_value();
      send_request(op, idx, val, 1'b0, '0);
    end
  endtask

  // Response side: random back-pressure plus one long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected response status=%0d position=%0d count=%0d",
                 $time, rsp_ch.status, rsp_ch.position, rsp_ch.count);
      end else begin
        exp_res = pending_results.pop_front();
        status_seen[exp_res.status]++;
        if (rsp_ch.status !== exp_res.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, exp_res.status, rsp_ch.status);
        end
        if (rsp_ch.position !== exp_res.position) begin
          errors++;
          $display("%0t: position expected %0d got %0d",
                   $time, exp_res.position, rsp_ch.position);
        end
        if (rsp_ch.count !== exp_res.count) begin
          errors++;
          $display("%0t: count expected %0d got %0d", $time, exp_res.count, rsp_ch.count);
        end
      end
    end
  end

  initial begin
    int i;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode  = olid_pkg::MODE_APPEND;
    req_ch.index = '0;
    req_ch.value = '0;
    list_len     = 0;
    growing      = 1'b0;
    turn_mark    = 2;
    src_idle_pct = 24;
    rcv_idle_pct = 86;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++)
      send_request(directed_steps[i].op, directed_steps[i].idx, directed_steps[i].val,
                   directed_steps[i].typed, directed_steps[i].res);

    // Fill to capacity, leaving a marker value in the last position
    while (list_len < LIST_CAPACITY - 1)
      send_request(olid_pkg::MODE_APPEND, olid_pkg::INDEX_W'($urandom_range(0, 255)),
                   pick_value(), 1'b0, '0);
    send_request(olid_pkg::MODE_APPEND, 8'd0, 32'sh600D_F00D, 1'b0, '0);
    send_request(olid_pkg::MODE_APPEND, 8'd0, 32'sd3, 1'b0, '0);
    send_request(olid_pkg::MODE_INSERT, 8'd0, 32'sd3, 1'b0, '0);
    send_request(olid_pkg::MODE_INSERT, 8'd255, 32'sd3, 1'b0, '0);
    send_request(olid_pkg::MODE_FIND, 8'd0, 32'sh600D_F00D, 1'b0, '0);
    send_request(olid_pkg::MODE_DELETE, 8'd255, 32'sd0, 1'b0, '0);
    send_request(olid_pkg::MODE_INSERT, 8'd254, VAL_MAX, 1'b0, '0);
    send_request(olid_pkg::MODE_DELETE, 8'd0, 32'sd0, 1'b0, '0);
    send_request(olid_pkg::MODE_FIND, 8'd0, 32'sh0BAD_CAFE, 1'b0, '0);
    random_requests(180);
    wait_drained();

    src_idle_pct = 86;
    rcv_idle_pct = 24;
    random_requests(200);
    wait_drained();

    src_idle_pct = 0;
    rcv_idle_pct = 0;
    random_requests(200);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d requests (%0d directed, full-list and random walk), %0d responses",
             requests_sent, DIRECTED_ROWS, results_seen);
    $display("Statuses seen: ok %0d, full %0d, out of range %0d, not found %0d",
             status_seen[olid_pkg::STATUS_OK], status_seen[olid_pkg::STATUS_FULL],
             status_seen[olid_pkg::STATUS_RANGE], status_seen[olid_pkg::STATUS_ABSENT]);
    if (errors == 0) begin
      $display("tb_ordered_list_insert_delete_find passed");
    end else begin
      $display("tb_ordered_list_insert_delete_find failed");
    end
    $finish;
  end

endmodule

// ===== ordered_list_insert_delete_find.f =====
design/olid_pkg.sv
design/olid_if.sv
design/olid_cell.sv
design/ordered_list_insert_delete_find.sv
dv/tb_ordered_list_insert_delete_find.sv
